// ===== design/sha256_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 engine package
// Shared word types, initial hash values, round constants and the
// rotate-and-mix functions used by the round logic.
// ----------------------------------------------------------------------------
package sha256_pkg;

  typedef logic [31:0] word_t;
  typedef word_t hash_arr_t [8];
  typedef word_t sched_arr_t [16];

  localparam int unsigned RoundsPerBlock = 64;
  localparam int unsigned CountWidth     = 61;

  localparam word_t InitH0 = 32'h6a09e667;
  localparam word_t InitH1 = 32'hbb67ae85;
  localparam word_t InitH2 = 32'h3c6ef372;
  localparam word_t InitH3 = 32'ha54ff53a;
  localparam word_t InitH4 = 32'h510e527f;
  localparam word_t InitH5 = 32'h9b05688c;
  localparam word_t InitH6 = 32'h1f83d9ab;
  localparam word_t InitH7 = 32'h5be0cd19;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos  = 6'd55;
  localparam logic [5:0] DigestPos = 6'd32;

  function automatic word_t init_h(input logic [2:0] idx);
    word_t r;
    unique case (idx)
      3'd0: r = InitH0;
      3'd1: r = InitH1;
      3'd2: r = InitH2;
      3'd3: r = InitH3;
      3'd4: r = InitH4;
      3'd5: r = InitH5;
      3'd6: r = InitH6;
      3'd7: r = InitH7;
      default: r = InitH0;
    endcase
    return r;
  endfunction

  function automatic word_t ror(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t round_k(input logic [5:0] t);
    word_t r;
    unique case (t)
      6'd0:  r = 32'h428a2f98;  6'd1:  r = 32'h71374491;
      6'd2:  r = 32'hb5c0fbcf;  6'd3:  r = 32'he9b5dba5;
      6'd4:  r = 32'h3956c25b;  6'd5:  r = 32'h59f111f1;
      6'd6:  r = 32'h923f82a4;  6'd7:  r = 32'hab1c5ed5;
      6'd8:  r = 32'hd807aa98;  6'd9:  r = 32'h12835b01;
      6'd10: r = 32'h243185be;  6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74;  6'd13: r = 32'h80deb1fe;
      6'd14: r = 32'h9bdc06a7;  6'd15: r = 32'hc19bf174;
      6'd16: r = 32'he49b69c1;  6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6;  6'd19: r = 32'h240ca1cc;
      6'd20: r = 32'h2de92c6f;  6'd21: r = 32'h4a7484aa;
      6'd22: r = 32'h5cb0a9dc;  6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152;  6'd25: r = 32'ha831c66d;
      6'd26: r = 32'hb00327c8;  6'd27: r = 32'hbf597fc7;
      6'd28: r = 32'hc6e00bf3;  6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351;  6'd31: r = 32'h14292967;
      6'd32: r = 32'h27b70a85;  6'd33: r = 32'h2e1b2138;
      6'd34: r = 32'h4d2c6dfc;  6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354;  6'd37: r = 32'h766a0abb;
      6'd38: r = 32'h81c2c92e;  6'd39: r = 32'h92722c85;
      6'd40: r = 32'ha2bfe8a1;  6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70;  6'd43: r = 32'hc76c51a3;
      6'd44: r = 32'hd192e819;  6'd45: r = 32'hd6990624;
      6'd46: r = 32'hf40e3585;  6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116;  6'd49: r = 32'h1e376c08;
      6'd50: r = 32'h2748774c;  6'd51: r = 32'h34b0bcb5;
      6'd52: r = 32'h391c0cb3;  6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f;  6'd55: r = 32'h682e6ff3;
      6'd56: r = 32'h748f82ee;  6'd57: r = 32'h78a5636f;
      6'd58: r = 32'h84c87814;  6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa;  6'd61: r = 32'ha4506ceb;
      6'd62: r = 32'hbef9a3f7;  6'd63: r = 32'hc67178f2;
      default: r = 32'h428a2f98;
    endcase
    return r;
  endfunction

endpackage

// ===== design/sha256_round.sv =====
// ----------------------------------------------------------------------------
// SHA-256 round unit
// One compression round on the working variables, plus the next word of
// the message schedule from the sixteen-word window.
// ----------------------------------------------------------------------------
module sha256_round import sha256_pkg::*; (
  input  hash_arr_t  v_i,
  input  sched_arr_t w_i,
  input  word_t      k_i,
  output hash_arr_t  v_o,
  output word_t      w_new_o
);

  word_t t1;
  word_t t2;

  always_comb begin
    t1 = v_i[7] + big_sigma1(v_i[4]) + ((v_i[4] & v_i[5]) ^ (~v_i[4] & v_i[6]))
         + k_i + w_i[0];
    t2 = big_sigma0(v_i[0])
         + ((v_i[0] & v_i[1]) ^ (v_i[0] & v_i[2]) ^ (v_i[1] & v_i[2]));
    v_o[7] = v_i[6];
    v_o[6] = v_i[5];
    v_o[5] = v_i[4];
    v_o[4] = v_i[3] + t1;
    v_o[3] = v_i[2];
    v_o[2] = v_i[1];
    v_o[1] = v_i[0];
    v_o[0] = t1 + t2;
    w_new_o = small_sigma1(w_i[14]) + w_i[9] + small_sigma0(w_i[1]) + w_i[0];
  end

endmodule

// ===== design/sha256_hash_engine.sv =====
// Flow: a word is held while its valid bytes are packed, a full block runs the rounds and
// the hash add, and a last word adds the padding bytes (one a cycle outside the rounds), one
// or two blocks (one more with double hashing), the length and finish states and eight
// output transactions. One transaction at a time: input stalls while a word is packed and
// while each 16-word block is compressed by the single round unit.
// Reset (synchronous, active low) restores the initial hash and clears counts.
// ----------------------------------------------------------------------------
// SHA-256 hash engine
// Packs message bytes into a block window, compresses each full block with a
// shared round unit, pads on the last word and streams out the digest.
// ----------------------------------------------------------------------------
module sha256_hash_engine import sha256_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_message_word,
  input  logic [2:0]  in_valid_bytes,
  input  logic        in_last_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_digest_last
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_BYTE  = 8'b0000_0010,
    ST_ROUND = 8'b0000_0100,
    ST_ADD   = 8'b0000_1000,
    ST_PAD   = 8'b0001_0000,
    ST_LEN   = 8'b0010_0000,
    ST_FIN   = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_t;

  state_t                  state_r, state_nxt, ret_r, ret_nxt;
  hash_arr_t               hash_r, hash_nxt, v_r, v_nxt, v_rnd;
  sched_arr_t              w_r, w_nxt;
  word_t                   w_new;
  logic [CountWidth-1:0]   cnt_r, cnt_nxt;
  logic [5:0]              rnd_r, rnd_nxt, pos_r, pos_nxt;
  logic [31:0]             word_r, word_nxt;
  logic [2:0]              nleft_r, nleft_nxt, idx_r, idx_nxt;
  logic                    last_r, last_nxt, first_r, first_nxt;
  logic                    second_r, second_nxt, double_r;
  logic                    wr_en;
  logic [5:0]              wr_pos;
  logic [7:0]              wr_byte;
  logic [63:0]             len_bits;

  sha256_round u_round (
    .v_i     (v_r),
    .w_i     (w_r),
    .k_i     (round_k(rnd_r)),
    .v_o     (v_rnd),
    .w_new_o (w_new)
  );

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = (state_r == ST_OUT);
  assign out_digest_word = hash_r[0];
  assign out_word_index  = idx_r;
  assign out_digest_last = (idx_r == 3'd7);
  assign len_bits        = second_r ? 64'd256 : {cnt_r, 3'b000};

  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    hash_nxt   = hash_r;
    v_nxt      = v_r;
    w_nxt      = w_r;
    cnt_nxt    = cnt_r;
    rnd_nxt    = rnd_r;
    pos_nxt    = pos_r;
    word_nxt   = word_r;
    nleft_nxt  = nleft_r;
    idx_nxt    = idx_r;
    last_nxt   = last_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    wr_en      = 1'b0;
    wr_pos     = cnt_r[5:0];
    wr_byte    = word_r[31:24];

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          word_nxt  = in_message_word;
          nleft_nxt = (in_valid_bytes > 3'd4) ? 3'd4 : in_valid_bytes;
          last_nxt  = in_last_word;
          state_nxt = ST_BYTE;
        end
      end
      ST_BYTE: begin
        if (nleft_r == 3'd0) begin
          if (last_r) begin
            pos_nxt   = cnt_r[5:0];
            first_nxt = 1'b1;
            state_nxt = ST_PAD;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          wr_en     = 1'b1;
          word_nxt  = {word_r[23:0], 8'h00};
          nleft_nxt = nleft_r - 3'd1;
          cnt_nxt   = cnt_r + 1'b1;
          if (cnt_r[5:0] == 6'd63) begin
            v_nxt     = hash_r;
            rnd_nxt   = 6'd0;
            ret_nxt   = ST_BYTE;
            state_nxt = ST_ROUND;
          end
        end
      end
      ST_ROUND: begin
        v_nxt = v_rnd;
        for (int i = 0; i < 15; i++) begin
          w_nxt[i] = w_r[i+1];
        end
        w_nxt[15] = w_new;
        rnd_nxt   = rnd_r + 6'd1;
        if (rnd_r == 6'(RoundsPerBlock - 1)) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        for (int i = 0; i < 8; i++) begin
          hash_nxt[i] = hash_r[i] + v_r[i];
        end
        state_nxt = ret_r;
      end
      ST_PAD: begin
        wr_en     = 1'b1;
        wr_pos    = pos_r;
        wr_byte   = first_r ? PadByte : 8'h00;
        first_nxt = 1'b0;
        pos_nxt   = pos_r + 6'd1;
        if (pos_r == 6'd63) begin
          v_nxt     = hash_r;
          rnd_nxt   = 6'd0;
          ret_nxt   = ST_PAD;
          state_nxt = ST_ROUND;
        end else if (pos_r == LenPos) begin
          state_nxt = ST_LEN;
        end
      end
      ST_LEN: begin
        w_nxt[14] = len_bits[63:32];
        w_nxt[15] = len_bits[31:0];
        v_nxt     = hash_r;
        rnd_nxt   = 6'd0;
        ret_nxt   = ST_FIN;
        state_nxt = ST_ROUND;
      end
      ST_FIN: begin
        if (double_r && !second_r) begin
          for (int i = 0; i < 8; i++) begin
            w_nxt[i]    = hash_r[i];
            hash_nxt[i] = init_h(3'(i));
          end
          second_nxt = 1'b1;
          pos_nxt    = DigestPos;
          first_nxt  = 1'b1;
          state_nxt  = ST_PAD;
        end else begin
          second_nxt = 1'b0;
          idx_nxt    = 3'd0;
          state_nxt  = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          for (int i = 0; i < 7; i++) begin
            hash_nxt[i] = hash_r[i+1];
          end
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            for (int i = 0; i < 8; i++) begin
              hash_nxt[i] = init_h(3'(i));
            end
            cnt_nxt   = '0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (wr_en) begin
      for (int i = 0; i < 16; i++) begin
        if (wr_pos[5:2] == 4'(i)) begin
          unique case (wr_pos[1:0])
            2'd0: w_nxt[i][31:24] = wr_byte;
            2'd1: w_nxt[i][23:16] = wr_byte;
            2'd2: w_nxt[i][15:8]  = wr_byte;
            2'd3: w_nxt[i][7:0]   = wr_byte;
            default: w_nxt[i][7:0] = wr_byte;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ret_r    <= ST_IDLE;
      cnt_r    <= '0;
      rnd_r    <= '0;
      idx_r    <= '0;
      second_r <= 1'b0;
      double_r <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        hash_r[i] <= init_h(3'(i));
      end
    end else begin
      state_r  <= state_nxt;
      ret_r    <= ret_nxt;
      cnt_r    <= cnt_nxt;
      rnd_r    <= rnd_nxt;
      idx_r    <= idx_nxt;
      second_r <= second_nxt;
      hash_r   <= hash_nxt;
      if (cfg_wr_en) begin
        double_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    v_r     <= v_nxt;
    w_r     <= w_nxt;
    pos_r   <= pos_nxt;
    word_r  <= word_nxt;
    nleft_r <= nleft_nxt;
    last_r  <= last_nxt;
    first_r <= first_nxt;
  end

endmodule

// ===== design/sha256_checker.sv =====
// ----------------------------------------------------------------------------
// SHA-256 engine port checker
// Watches the ports of the hash engine for digest ordering and for the
// engine holding off input while a digest is delivered.
// ----------------------------------------------------------------------------
module sha256_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_word_index,
  input logic        out_digest_last
);

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_digest_word)
                               && $stable(out_word_index))
    else $error("digest payload changed while stalled");

  // No message transaction is taken while a digest is being delivered.
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted during digest output");

  // The last flag marks exactly the eighth word.
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digest_last == (out_word_index == 3'd7)))
    else $error("digest_last does not match word index");

  // Digest words follow one another without gaps.
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_digest_last |=>
      out_valid && (out_word_index == 3'($past(out_word_index) + 3'd1)))
    else $error("digest words out of sequence");

endmodule

bind sha256_hash_engine sha256_checker u_sha256_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_digest_word (out_digest_word),
  .out_word_index  (out_word_index),
  .out_digest_last (out_digest_last)
);

// ===== bench/sha256_hash_engine_tb.sv =====
// ----------------------------------------------------------------------------
// SHA-256 hash engine testbench
// Streams messages of random length and content into the engine, with
// directed corner messages first, and checks every digest word against a
// behavioural SHA-256 (and double SHA-256) computed alongside the stimulus.
// ----------------------------------------------------------------------------
module sha256_hash_engine_tb;
  import sha256_pkg::*;

  typedef struct packed {
    logic [31:0] msg_word;
    logic [2:0]  nbytes;
    logic        last;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] dword;
    logic [2:0]  idx;
    logic        dlast;
  } digest_item_t;

  localparam logic [60:0] CountMask = {61{1'b1}};

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_message_word;
  logic [2:0]  in_valid_bytes;
  logic        in_last_word;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_digest_last;

  msg_item_t    word_queue[$];
  digest_item_t digest_queue[$];
  int           errors;
  int           send_idle_pct;
  int           recv_idle_pct;
  bit           hold_off;

  word_t       hstate[8];
  word_t       blk[16];
  logic [60:0] nbytes_seen;
  bit          dbl_mode;

  sha256_hash_engine dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_message_word(in_message_word), .in_valid_bytes(in_valid_bytes),
    .in_last_word(in_last_word),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_digest_word(out_digest_word), .out_word_index(out_word_index),
    .out_digest_last(out_digest_last)
  );

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  function automatic word_t rotr(word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t kconst(int t);
    word_t kt[64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return kt[t];
  endfunction

  task automatic load_initial_hash();
    hstate = '{InitH0, InitH1, InitH2, InitH3, InitH4, InitH5, InitH6, InitH7};
  endtask

  task automatic compress_block();
    word_t w[64];
    word_t v[8];
    word_t s0, s1, t1, t2;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    v = hstate;
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + kconst(i) + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hstate[i] += v[i];
  endtask

  task automatic place_byte(int pos, logic [7:0] b);
    blk[(pos >> 2) & 15][(3 - (pos & 3)) * 8 +: 8] = b;
  endtask

  task automatic pad_and_close(logic [60:0] count);
    logic [63:0] bits;
    int pos;
    bits = {count, 3'b000};
    pos = count[5:0];
    place_byte(pos, 8'h80);
    pos++;
    if (pos > 56) begin
      while (pos < 64) begin place_byte(pos, 8'h00); pos++; end
      compress_block();
      pos = 0;
    end
    while (pos < 56) begin place_byte(pos, 8'h00); pos++; end
    blk[14] = bits[63:32];
    blk[15] = bits[31:0];
    compress_block();
  endtask

  task automatic absorb_word(msg_item_t it);
    int n;
    n = (it.nbytes > 4) ? 4 : it.nbytes;
    for (int i = 0; i < n; i++) begin
      place_byte(nbytes_seen[5:0], it.msg_word[(3 - i) * 8 +: 8]);
      nbytes_seen = (nbytes_seen + 61'd1) & CountMask;
      if (nbytes_seen[5:0] == 6'd0) compress_block();
    end
    if (it.last) begin
      pad_and_close(nbytes_seen);
      if (dbl_mode) begin
        for (int i = 0; i < 8; i++) blk[i] = hstate[i];
        load_initial_hash();
        pad_and_close(61'd32);
      end
      for (int i = 0; i < 8; i++)
        digest_queue.push_back('{hstate[i], i[2:0], i == 7});
      load_initial_hash();
      nbytes_seen = '0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        absorb_word('{in_message_word, in_valid_bytes, in_last_word});
        void'(word_queue.pop_front());
      end
      if (!in_valid || !in_stall) begin
        if (word_queue.size() > 0 && !hold_off
            && ($urandom_range(99) >= send_idle_pct)) begin
          in_valid        <= 1'b1;
          in_message_word <= word_queue[0].msg_word;
          in_valid_bytes  <= word_queue[0].nbytes;
          in_last_word    <= word_queue[0].last;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    digest_item_t exp_d;
    if (rst_n && out_valid && !out_stall) begin
      if (digest_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected digest word %h index %0d", $time,
                 out_digest_word, out_word_index);
      end else begin
        exp_d = digest_queue.pop_front();
        if (exp_d != {out_digest_word, out_word_index, out_digest_last}) begin
          errors++;
          $display("%0t: digest mismatch, expected %h/%0d/%b, got %h/%0d/%b", $time,
                   exp_d.dword, exp_d.idx, exp_d.dlast,
                   out_digest_word, out_word_index, out_digest_last);
        end
      end
    end
  end

  task automatic queue_message(int nwords, bit random_sizes);
    msg_item_t it;
    for (int i = 0; i < nwords; i++) begin
      it.msg_word = $urandom();
      it.last = (i == nwords - 1);
      it.nbytes = random_sizes ? $urandom_range(7) : 3'd4;
      if (it.last && random_sizes && $urandom_range(3) == 0) it.nbytes = $urandom_range(4);
      word_queue.push_back(it);
    end
  endtask

  task automatic drain();
    while (word_queue.size() != 0 || in_valid || digest_queue.size() != 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_mode(bit v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    dbl_mode = v;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    in_valid = 1'b0;
    in_message_word = '0;
    in_valid_bytes = '0;
    in_last_word = 1'b0;
    out_stall = 1'b0;
    hold_off = 1'b0;
    errors = 0;
    send_idle_pct = 8;
    recv_idle_pct = 78;
    dbl_mode = 1'b0;
    nbytes_seen = '0;
    load_initial_hash();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty message, extremes of word values, short and oversized counts,
    // and message lengths that force an extra padding block.
    word_queue.push_back('{32'h00000000, 3'd0, 1'b1});
    word_queue.push_back('{32'hffffffff, 3'd4, 1'b1});
    word_queue.push_back('{32'h00000000, 3'd4, 1'b0});
    word_queue.push_back('{32'h12345678, 3'd0, 1'b0});
    word_queue.push_back('{32'hffffffff, 3'd7, 1'b0});
    word_queue.push_back('{32'ha5a5a5a5, 3'd1, 1'b0});
    word_queue.push_back('{32'h5a5a5a5a, 3'd3, 1'b0});
    word_queue.push_back('{32'hdeadbeef, 3'd2, 1'b1});
    queue_message(14, 1'b0);
    queue_message(16, 1'b0);
    drain();

    write_mode(1'b1);
    word_queue.push_back('{32'h61626300, 3'd3, 1'b1});
    word_queue.push_back('{32'hffffffff, 3'd5, 1'b1});
    queue_message(20, 1'b1);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 78 : 0;
      recv_idle_pct = (phase == 0) ? 78 : (phase == 1) ? 8 : 0;
      write_mode(phase != 1);
      for (int m = 0; m < 5; m++) queue_message($urandom_range(1, 14), 1'b1);
      // Hold the sender until every outstanding digest has been read.
      while (word_queue.size() >= 4) @(posedge clk);
      hold_off = 1'b1;
      while (in_valid || digest_queue.size() != 0) @(posedge clk);
      hold_off = 1'b0;
      drain();
    end
    write_mode(1'b0);
    queue_message(3, 1'b1);
    drain();

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
design/sha256_pkg.sv
design/sha256_round.sv
design/sha256_hash_engine.sv
design/sha256_checker.sv
bench/sha256_hash_engine_tb.sv
